[rtl/prq_pkg.sv]
// Package for the priority ready queue: transaction payload types, opcodes
// and default sizes. No dependencies.

package prq_pkg;

    localparam int PRQ_LEVELS  = 256;
    localparam int PRQ_THREADS = 256;

    localparam logic [1:0] OP_STORE    = 2'd0;
    localparam logic [1:0] OP_RETRIEVE = 2'd1;
    localparam logic [1:0] OP_EXCHANGE = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] thread_id;
        logic [7:0] thread_priority;
    } t_prq_in;

    typedef struct packed {
        logic       found;
        logic [7:0] chosen_thread;
        logic [7:0] top_level;
    } t_prq_out;

endpackage

[rtl/priority_ready_queue_core.sv]
// Multilevel round-robin ready queue: head, next and previous link memories
// with an occupancy vector and a chunked downward search for the top level.
// Depends on prq_pkg.
//
// Store: S_ENQ, and S_ENQ_HEAD/TAIL/LINK when the level already holds threads.
// Retrieve: S_DEQ, plus S_DEQ_HEAD/LINK unless the top level is 0 or empty,
// plus S_SEARCH downward in groups of 16 levels when a level empties.
// Exchange: handed straight back, or a store then a retrieve. All end in S_EMIT.
// One transaction at a time: o_in_stall falls as o_out_valid rises.
// Reset empties every level at once through the occupancy flip-flops.

module priority_ready_queue_core
    import prq_pkg::*;
#(
    parameter int LEVELS  = PRQ_LEVELS,
    parameter int THREADS = PRQ_THREADS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_prq_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_prq_out o_out_data
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = $clog2(THREADS);
    localparam int LP = 1 << LW;
    localparam int GB = (LW < 4) ? LW : 4;
    localparam int GS = 1 << GB;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_ENQ      = 10'b0000000010,
        S_ENQ_HEAD = 10'b0000000100,
        S_ENQ_TAIL = 10'b0000001000,
        S_ENQ_LINK = 10'b0000010000,
        S_DEQ      = 10'b0000100000,
        S_DEQ_HEAD = 10'b0001000000,
        S_DEQ_LINK = 10'b0010000000,
        S_SEARCH   = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [LEVELS-1:0] r_occ;
    logic [LW-1:0]   r_hl;
    logic            r_ovalid;
    t_prq_out        r_out;

    logic [TW-1:0]   r_tid;
    logic [LW-1:0]   r_lvl;
    logic            r_xchg;
    logic            r_found;
    logic [7:0]      r_chosen;
    logic [TW-1:0]   r_head;
    logic [TW-1:0]   r_tail;
    logic [LW-1:0]   r_scan;

    logic [TW-1:0]   hd_mem [LEVELS];
    logic [TW-1:0]   nl_mem [THREADS];
    logic [TW-1:0]   pl_mem [THREADS];
    logic [TW-1:0]   r_h_q;
    logic [TW-1:0]   r_n_q;
    logic [TW-1:0]   r_p_q;

    logic            hd_we;
    logic [LW-1:0]   hd_wa;
    logic [TW-1:0]   hd_wd;
    logic [LW-1:0]   hd_ra;
    logic            nl_we;
    logic [TW-1:0]   nl_wa;
    logic [TW-1:0]   nl_wd;
    logic            pl_we;
    logic [TW-1:0]   pl_wa;
    logic [TW-1:0]   pl_wd;

    logic [LP-1:0]   occ_pad;
    logic            in_ok;
    logic            bypass;
    logic            lvl_empty;
    logic            deq_none;
    logic            last_one;
    logic            out_free;
    logic [LW-1:0]   scan_base;
    logic [GS-1:0]   scan_grp;
    logic            scan_hit;
    logic [GB-1:0]   scan_pos;

    assign occ_pad   = LP'(r_occ);
    assign in_ok     = (32'(i_in_data.thread_id) < THREADS) &&
                       (32'(i_in_data.thread_priority) < LEVELS);
    assign bypass    = !in_ok || (8'(r_hl) < i_in_data.thread_priority);
    assign lvl_empty = !occ_pad[r_lvl];
    assign deq_none  = (r_hl == '0) || !occ_pad[r_hl];
    assign last_one  = (r_n_q == r_head);
    assign out_free  = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // search the current group of levels at and below r_scan
    always_comb begin
        scan_base = r_scan & ~LW'(GS - 1);
        scan_grp  = occ_pad[scan_base +: GS];
        scan_hit  = 1'b0;
        scan_pos  = '0;
        for (int i = 0; i < GS; i++) begin
            if (scan_grp[i] && (GB'(i) <= r_scan[GB-1:0])) begin
                scan_hit = 1'b1;
                scan_pos = GB'(i);
            end
        end
    end

    always_comb begin
        hd_we = 1'b0;
        hd_wa = r_lvl;
        hd_wd = r_tid;
        hd_ra = (r_state == S_DEQ) ? r_hl : r_lvl;
        nl_we = 1'b0;
        nl_wa = r_tid;
        nl_wd = r_tid;
        pl_we = 1'b0;
        pl_wa = r_tid;
        pl_wd = r_tid;
        case (r_state)
            S_ENQ: begin
                if (lvl_empty) begin
                    hd_we = 1'b1;
                    nl_we = 1'b1;
                    pl_we = 1'b1;
                end
            end
            S_ENQ_TAIL: begin
                nl_we = 1'b1;
                nl_wd = r_head;
                pl_we = 1'b1;
                pl_wd = r_p_q;
            end
            S_ENQ_LINK: begin
                nl_we = 1'b1;
                nl_wa = r_tail;
                pl_we = 1'b1;
                pl_wa = r_head;
            end
            S_DEQ_LINK: begin
                if (!last_one) begin
                    hd_we = 1'b1;
                    hd_wa = r_hl;
                    hd_wd = r_n_q;
                    nl_we = 1'b1;
                    nl_wa = r_p_q;
                    nl_wd = r_n_q;
                    pl_we = 1'b1;
                    pl_wa = r_n_q;
                    pl_wd = r_p_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            hd_mem[hd_wa] <= hd_wd;
        end
        r_h_q <= hd_mem[hd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nl_we) begin
            nl_mem[nl_wa] <= nl_wd;
        end
        r_n_q <= nl_mem[r_h_q];
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            pl_mem[pl_wa] <= pl_wd;
        end
        r_p_q <= pl_mem[r_h_q];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.opcode)
                        OP_STORE:    n_state = in_ok ? S_ENQ : S_EMIT;
                        OP_RETRIEVE: n_state = S_DEQ;
                        OP_EXCHANGE: n_state = bypass ? S_EMIT : S_ENQ;
                        default:     n_state = S_EMIT;
                    endcase
                end
            end
            S_ENQ:      n_state = lvl_empty ? (r_xchg ? S_DEQ : S_EMIT) : S_ENQ_HEAD;
            S_ENQ_HEAD: n_state = S_ENQ_TAIL;
            S_ENQ_TAIL: n_state = S_ENQ_LINK;
            S_ENQ_LINK: n_state = r_xchg ? S_DEQ : S_EMIT;
            S_DEQ:      n_state = deq_none ? S_EMIT : S_DEQ_HEAD;
            S_DEQ_HEAD: n_state = S_DEQ_LINK;
            S_DEQ_LINK: n_state = last_one ? S_SEARCH : S_EMIT;
            S_SEARCH: begin
                if (scan_hit || scan_base == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_hl     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_ENQ: begin
                    r_occ[r_lvl] <= 1'b1;
                    if (r_lvl > r_hl) begin
                        r_hl <= r_lvl;
                    end
                end
                S_DEQ_LINK: begin
                    if (last_one) begin
                        r_occ[r_hl] <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    if (scan_hit) begin
                        r_hl <= scan_base | LW'(scan_pos);
                    end else if (scan_base == '0) begin
                        r_hl <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tid    <= TW'(i_in_data.thread_id);
                r_lvl    <= LW'(i_in_data.thread_priority);
                r_xchg   <= (i_in_data.opcode == OP_EXCHANGE);
                r_found  <= (i_in_data.opcode == OP_EXCHANGE) && bypass;
                r_chosen <= (i_in_data.opcode == OP_EXCHANGE && bypass) ?
                            i_in_data.thread_id : '0;
            end
            S_ENQ_HEAD: r_head <= r_h_q;
            S_ENQ_TAIL: r_tail <= r_p_q;
            S_DEQ_HEAD: r_head <= r_h_q;
            S_DEQ_LINK: begin
                r_found  <= 1'b1;
                r_chosen <= 8'(r_head);
                r_scan   <= r_hl;
            end
            S_SEARCH: begin
                if (!scan_hit) begin
                    r_scan <= scan_base - LW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out.found         <= r_found;
                    r_out.chosen_thread <= r_chosen;
                    r_out.top_level     <= 8'(r_hl);
                end
            end
            default: begin
            end
        endcase
    end

endmodule
